// ----- rtl/core/avmd_pkg.sv -----
// shared types, constants and codes for the avi movi chunk demultiplexer
// used by every module of the block, depends on nothing

package avmd_pkg;

   // fixed field widths
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 33;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 1;

   // defaults handed to the top level parameters
   localparam int unsigned SIZE_BITS_DEFAULT  = 32;
   localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOVIE_LIST_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHUNK_BYTES = 1'b1;

   // register reset values
   localparam logic [WORD_W-1:0] MOVIE_LIST_SIZE_RESET = 32'd0;
   localparam logic [WORD_W-1:0] MAX_CHUNK_BYTES_RESET = 32'd65536;

   // little-endian four-character chunk ids
   localparam logic [WORD_W-1:0] ID_VIDEO_COMPRESSED = 32'h6364_3030; // 00dc
   localparam logic [WORD_W-1:0] ID_VIDEO_BITMAP     = 32'h6264_3030; // 00db
   localparam logic [WORD_W-1:0] ID_AUDIO            = 32'h6277_3130; // 01wb
   localparam logic [WORD_W-1:0] ID_LIST             = 32'h5453_494C; // LIST

   // saturation point of the list position
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // input kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REWIND = 1'b1;

   // stream kinds
   localparam logic STREAM_VIDEO = 1'b0;
   localparam logic STREAM_AUDIO = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_PAYLOAD   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_END_ONLY  = 2'd3;

   // parser phases
   typedef enum logic [2:0] {
      PHASE_ID      = 3'd0,
      PHASE_SIZE    = 3'd1,
      PHASE_LTYPE   = 3'd2,
      PHASE_PAYLOAD = 3'd3,
      PHASE_SKIP    = 3'd4,
      PHASE_PAD     = 3'd5
   } phase_type;

   // input item
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_byte;
      logic                stream_kind;
      logic [WORD_W-1:0]   chunk_length;
      logic                last_of_chunk;
      logic [WORD_W-1:0]   video_frame_index;
      logic                movie_end;
   } rsp_item_type;

endpackage

// ----- rtl/core/avmd_parser.sv -----
// front part: accepts movi list bytes, walks the chunk structure, builds results
// depends on avmd_pkg

module avmd_parser #(
   parameter int unsigned SIZE_BITS = avmd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [avmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [avmd_pkg::WORD_W-1:0]        csr_wdata,
   input  logic                               item_valid,
   input  avmd_pkg::req_item_type             item,
   output logic                               res_valid,
   output avmd_pkg::rsp_item_type             res
);
   import avmd_pkg::*;

   localparam logic [WORD_W-1:0] SIZE_MASK = WORD_W'((64'd1 << SIZE_BITS) - 64'd1);

   // configuration registers
   logic [WORD_W-1:0] movie_list_size_ff, movie_list_size_in;
   logic [WORD_W-1:0] max_chunk_ff, max_chunk_in;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [1:0]         field_count_ff, field_count_in;
   logic [WORD_W-1:0]  id_ff, id_in;
   logic [WORD_W-1:0]  size_ff, size_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic               stream_ff, stream_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [WORD_W-1:0]  vid_count_ff, vid_count_in;
   logic               halted_ff, halted_in;
   logic               finished_ff, finished_in;

   // decode
   logic               rewind, step, at_bound, end_drop, work, field_last;
   logic [WORD_W-1:0]  size_shift, size_masked, frame_idx;
   logic               size_zero, too_large, is_list, is_vid, is_aud, is_stream;
   logic [SIZE_BITS-1:0] rem_dec;
   logic               rem_last, odd;
   logic [POS_W-1:0]   pos_inc;
   logic               pos_ge, pos_ge_next;
   logic               chunk_bound, bound_res, end_hit;

   // configuration writes
   always_comb begin
      movie_list_size_in = movie_list_size_ff;
      max_chunk_in       = max_chunk_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MOVIE_LIST_SIZE: movie_list_size_in = csr_wdata;
            CSR_MAX_CHUNK_BYTES: max_chunk_in       = csr_wdata;
            default: ;
         endcase
      end
   end

   // shared decode of the current byte
   always_comb begin
      rewind     = item_valid && (item.kind == KIND_REWIND);
      step       = item_valid && (item.kind == KIND_BYTE) && !halted_ff && !finished_ff;
      at_bound   = (phase_ff != PHASE_SIZE) && (phase_ff != PHASE_LTYPE) &&
                   (phase_ff != PHASE_PAYLOAD) && (phase_ff != PHASE_SKIP) &&
                   (phase_ff != PHASE_PAD) && (field_count_ff == 2'd0);
      pos_ge     = position_ff >= {1'b0, movie_list_size_ff};
      end_drop   = step && at_bound && pos_ge;
      work       = step && !end_drop;
      field_last = field_count_ff == 2'd3;
      size_shift  = {item.data_byte, size_ff[WORD_W-1:BYTE_W]};
      size_masked = size_shift & SIZE_MASK;
      size_zero   = size_masked == '0;
      too_large   = size_masked > max_chunk_ff;
      is_list     = id_ff == ID_LIST;
      is_vid      = (id_ff == ID_VIDEO_COMPRESSED) || (id_ff == ID_VIDEO_BITMAP);
      is_aud      = id_ff == ID_AUDIO;
      is_stream   = is_vid || is_aud;
      rem_dec     = remaining_ff - SIZE_BITS'(1);
      rem_last    = remaining_ff == SIZE_BITS'(1);
      odd         = size_ff[0];
      pos_inc     = position_ff + POS_W'(position_ff != POS_MAX);
      pos_ge_next = pos_inc >= {1'b0, movie_list_size_ff};
      frame_idx   = (stream_ff == STREAM_AUDIO) ? vid_count_ff : vid_count_ff - 32'd1;

      // chunk ends at this byte, with or without a result of its own
      chunk_bound = 1'b0;
      bound_res   = 1'b0;
      case (phase_ff)
         PHASE_SIZE: begin
            if (field_last && !is_list && size_zero) begin
               if (!is_stream) begin
                  chunk_bound = 1'b1;
               end else if (!too_large) begin
                  chunk_bound = 1'b1;
                  bound_res   = 1'b1;
               end
            end
         end
         PHASE_LTYPE:   chunk_bound = field_last;
         PHASE_PAYLOAD: begin
            chunk_bound = rem_last && !odd;
            bound_res   = rem_last && !odd;
         end
         PHASE_SKIP:    chunk_bound = rem_last && !odd;
         PHASE_PAD:     chunk_bound = 1'b1;
         default:       chunk_bound = 1'b0;
      endcase
      end_hit = work && chunk_bound && pos_ge_next;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (rewind) begin
         phase_in = PHASE_ID;
      end else if (work) begin
         case (phase_ff)
            PHASE_SIZE: begin
               if (field_last) begin
                  if (is_list) begin
                     phase_in = PHASE_LTYPE;
                  end else if (is_stream) begin
                     if (!too_large) phase_in = size_zero ? PHASE_ID : PHASE_PAYLOAD;
                  end else begin
                     phase_in = size_zero ? PHASE_ID : PHASE_SKIP;
                  end
               end
            end
            PHASE_LTYPE: begin
               if (field_last) phase_in = PHASE_ID;
            end
            PHASE_PAYLOAD, PHASE_SKIP: begin
               if (rem_last) phase_in = odd ? PHASE_PAD : PHASE_ID;
            end
            PHASE_PAD: phase_in = PHASE_ID;
            default:   phase_in = field_last ? PHASE_SIZE : PHASE_ID;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      field_count_in = field_count_ff;
      id_in          = id_ff;
      size_in        = size_ff;
      remaining_in   = remaining_ff;
      stream_in      = stream_ff;
      position_in    = position_ff;
      vid_count_in   = vid_count_ff;
      halted_in      = halted_ff;
      finished_in    = finished_ff;
      res_valid      = 1'b0;
      res            = '0;

      if (rewind) begin
         field_count_in = '0;
         id_in          = '0;
         size_in        = '0;
         remaining_in   = '0;
         stream_in      = STREAM_VIDEO;
         position_in    = '0;
         vid_count_in   = '0;
         halted_in      = 1'b0;
         finished_in    = 1'b0;
      end else if (end_drop) begin
         // byte arriving past the end of the list
         finished_in           = 1'b1;
         res_valid             = 1'b1;
         res.status            = STATUS_END_ONLY;
         res.video_frame_index = vid_count_ff;
         res.movie_end         = 1'b1;
      end else if (work) begin
         position_in = pos_inc;
         case (phase_ff)
            PHASE_SIZE: begin
               size_in = size_shift;
               if (!field_last) begin
                  field_count_in = field_count_ff + 2'd1;
               end else begin
                  field_count_in = '0;
                  size_in        = size_masked;
                  if (!is_list) begin
                     remaining_in = size_masked[SIZE_BITS-1:0];
                  end
                  if (is_stream) begin
                     stream_in = is_aud ? STREAM_AUDIO : STREAM_VIDEO;
                     if (too_large) begin
                        halted_in             = 1'b1;
                        res_valid             = 1'b1;
                        res.status            = STATUS_TOO_LARGE;
                        res.stream_kind       = is_aud ? STREAM_AUDIO : STREAM_VIDEO;
                        res.chunk_length      = size_masked;
                        res.video_frame_index = vid_count_ff;
                     end else begin
                        if (is_vid) vid_count_in = vid_count_ff + 32'd1;
                        if (size_zero) begin
                           res_valid             = 1'b1;
                           res.status            = STATUS_EMPTY;
                           res.stream_kind       = is_aud ? STREAM_AUDIO : STREAM_VIDEO;
                           res.video_frame_index = vid_count_ff;
                        end
                     end
                  end
               end
            end
            PHASE_LTYPE: begin
               field_count_in = field_last ? 2'd0 : field_count_ff + 2'd1;
            end
            PHASE_PAYLOAD: begin
               remaining_in          = rem_dec;
               res_valid             = 1'b1;
               res.status            = STATUS_PAYLOAD;
               res.payload_byte      = item.data_byte;
               res.stream_kind       = stream_ff;
               res.chunk_length      = size_ff;
               res.last_of_chunk     = rem_last;
               res.video_frame_index = frame_idx;
            end
            PHASE_SKIP: begin
               remaining_in = rem_dec;
            end
            PHASE_PAD: begin
               field_count_in = '0;
            end
            default: begin
               id_in          = {item.data_byte, id_ff[WORD_W-1:BYTE_W]};
               field_count_in = field_last ? 2'd0 : field_count_ff + 2'd1;
            end
         endcase

         // end of list seen at a chunk boundary
         if (end_hit) begin
            finished_in = 1'b1;
            if (bound_res) begin
               res.movie_end = 1'b1;
            end else begin
               res_valid             = 1'b1;
               res                   = '0;
               res.status            = STATUS_END_ONLY;
               res.video_frame_index = vid_count_ff;
               res.movie_end         = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         movie_list_size_ff <= MOVIE_LIST_SIZE_RESET;
         max_chunk_ff       <= MAX_CHUNK_BYTES_RESET;
         phase_ff           <= PHASE_ID;
         field_count_ff     <= '0;
         id_ff              <= '0;
         size_ff            <= '0;
         remaining_ff       <= '0;
         stream_ff          <= STREAM_VIDEO;
         position_ff        <= '0;
         vid_count_ff       <= '0;
         halted_ff          <= 1'b0;
         finished_ff        <= 1'b0;
      end else begin
         movie_list_size_ff <= movie_list_size_in;
         max_chunk_ff       <= max_chunk_in;
         phase_ff           <= phase_in;
         field_count_ff     <= field_count_in;
         id_ff              <= id_in;
         size_ff            <= size_in;
         remaining_ff       <= remaining_in;
         stream_ff          <= stream_in;
         position_ff        <= position_in;
         vid_count_ff       <= vid_count_in;
         halted_ff          <= halted_in;
         finished_ff        <= finished_in;
      end
   end

`ifndef SYNTH
   // an oversize stream chunk halts the parser
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == STATUS_TOO_LARGE) |=> halted_ff)
      else $error("oversize chunk did not halt the parser");

   // an end result always marks the list finished
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.movie_end) |=> finished_ff)
      else $error("end of list not recorded");

   // nothing comes out of a halted or finished parser
   assert property (@(posedge clock) disable iff (reset)
      (halted_ff || finished_ff) |-> !res_valid)
      else $error("result produced while halted or finished");
`endif

endmodule

// ----- rtl/core/avmd_queue.sv -----
// back part: short result queue between the parser and the result port
// depends on avmd_pkg

module avmd_queue #(
   parameter int unsigned FIFO_DEPTH = avmd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  avmd_pkg::rsp_item_type  push_data,
   output logic                    full,
   output logic                    empty,
   input  logic                    pop,
   output avmd_pkg::rsp_item_type  pop_data
);
   import avmd_pkg::*;

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   rsp_item_type      entries [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   // transfer qualification and pointer update
   always_comb begin
      full      = count_ff == CNT_FULL;
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
      pop_data = entries[rd_ptr_ff];
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entries[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   // fill count stays within the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count out of range");

   // the parser never offers a result into a full queue
   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("result pushed into full queue");

   // a lone pop frees exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not free one entry");
`endif

endmodule

// ----- rtl/core/avi_movi_chunk_demuxer_top.sv -----
// Results: a result enters the result queue and reaches rsp_data at its head.
// Throughput: one byte or rewind per cycle, sustained; the parser takes every byte
// in one pass and only stops when the result queue (FIFO_DEPTH entries) is full.
// Reset: synchronous, active high; clears parse state and queue, loads the
// register defaults (list size 0, largest chunk 65536). A rewind keeps the registers.
// Depends on avmd_pkg, avmd_parser and avmd_queue.

module avi_movi_chunk_demuxer_top #(
   parameter int unsigned SIZE_BITS  = avmd_pkg::SIZE_BITS_DEFAULT,
   parameter int unsigned FIFO_DEPTH = avmd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [avmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [avmd_pkg::WORD_W-1:0]     csr_wdata,
   input  logic                            req_push,
   output logic                            req_full,
   input  avmd_pkg::req_item_type          req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output avmd_pkg::rsp_item_type          rsp_data
);
   import avmd_pkg::*;

   logic         item_valid;
   logic         res_valid;
   rsp_item_type res;

   // input transfer
   assign item_valid = req_push && !req_full;

   // front: chunk parser
   avmd_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (req_data),
      .res_valid  (res_valid),
      .res        (res)
   );

   // back: result queue
   avmd_queue #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (req_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );

endmodule
